// File: src/mlr_pkg.sv
// Shared widths, register indexes, datapath opcodes and controller/datapath bundles.
package mlr_pkg;

  localparam int SAMPLE_W               = 16;
  localparam int RATE_W                 = 18;
  localparam int IDX_W                  = 32;
  localparam int NUM_W                  = 36;
  localparam int DVD_W                  = 35;
  localparam int REG_IDX_W              = 2;
  localparam int RESULT_LIMIT           = 16;
  localparam int DEFAULT_MAX_RATE_RATIO = 8;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

  localparam logic [REG_IDX_W-1:0] REG_STEREO = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SETUP_PAIR,
    OP_SETUP_TAIL,
    OP_FOLD_START,
    OP_FOLD_DONE,
    OP_NO_FOLD,
    OP_CEIL_START,
    OP_CEIL_DONE,
    OP_STEP_MUL,
    OP_TOT_START,
    OP_TOT_DONE,
    OP_INTERP_MUL,
    OP_SUM,
    OP_QUOT_START,
    OP_QUOT_DONE,
    OP_PUT,
    OP_ADVANCE,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    logic in_ready;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic have_prev;
    logic last;
    logic fold_need;
    logic hit;
    logic more;
    logic div_done;
    logic put_ok;
    logic flush_ok;
  } stat_t;

endpackage

// File: src/mono_linear_resampler.sv
// Linear interpolation sample rate converter, mono output: top level.
//
// Frames arrive one word at a time and are handled one at a time; s_tready is high only
// between frames. A frame that reaches no output needs at most a position check, plus one
// division when a rate change has left the fractional position past one output period. A
// frame that reaches one or more outputs adds two divisions of position bookkeeping and
// then one division per output word; all divisions share the single serial divider (fold
// of the position, step count ceiling, position advance and each interpolation quotient).
// The final frame runs the position check once against the previous sample, if it has one,
// and once for the outputs past the last sample, and each pass works as above.
// A stalled m_tready lengthens the output phase, since one word is buffered. At most
// min(2*MAX_RATE_RATIO, 16) words leave per frame; later ones are dropped, the position
// still advances past them. The word carrying m_tlast is held until the final frame's work
// is done. Rates of zero act as one.
module mono_linear_resampler import mlr_pkg::*; #(
  parameter int MAX_RATE_RATIO = DEFAULT_MAX_RATE_RATIO
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // left_sample [15:0], right_sample [31:16]
  input  logic                 s_tlast,   // end_of_stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // out_sample [15:0]
  output logic                 m_tlast,   // final_flag
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  mlr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  mlr_datapath #(
    .MAX_RATE_RATIO (MAX_RATE_RATIO)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: src/mlr_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module mlr_divider import mlr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient,
  output logic [RATE_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DVD_W-1:0]  acc;
  logic [RATE_W-1:0] prem;
  logic [RATE_W-1:0] dvs;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;

  assign trial = {prem, acc[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= dividend;
      prem <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      acc  <= {acc[DVD_W-2:0], ge};
      prem <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    end
  end

  assign quotient  = acc;
  assign remainder = prem;

endmodule

// File: src/mlr_datapath.sv
// Resampler datapath: registers, stream position, interpolation arithmetic and output staging.
module mlr_datapath import mlr_pkg::*; #(
  parameter int MAX_RATE_RATIO = DEFAULT_MAX_RATE_RATIO
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  localparam int CAP   = (2 * MAX_RATE_RATIO < RESULT_LIMIT) ? 2 * MAX_RATE_RATIO : RESULT_LIMIT;
  localparam int CNT_W = $clog2(CAP + 1);

  // configuration
  logic              stereo;
  logic [RATE_W-1:0] src_rate;
  logic [RATE_W-1:0] tgt_rate;
  logic [RATE_W-1:0] s_eff;
  logic [RATE_W-1:0] t_eff;

  // stream state
  logic signed [SAMPLE_W-1:0] prev;
  logic                       have_prev;
  logic [IDX_W-1:0]           in_idx;
  logic [IDX_W-1:0]           npi;
  logic [RATE_W-1:0]          npr;

  // per item and per emit working registers
  logic signed [SAMPLE_W-1:0] x;
  logic                       last;
  logic [IDX_W-1:0]           k;
  logic signed [SAMPLE_W-1:0] a;
  logic signed [SAMPLE_W-1:0] b;
  logic [RATE_W-1:0]          rem;
  logic [RATE_W:0]            r;
  logic [RATE_W-1:0]          n;
  logic [RATE_W:0]            ns;
  logic signed [NUM_W-1:0]    at;
  logic signed [NUM_W-1:0]    prod;
  logic signed [NUM_W-1:0]    num;
  logic [SAMPLE_W-1:0]        val;
  logic [CNT_W-1:0]           count;

  // output staging
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_final;
  logic [SAMPLE_W-1:0] pend;
  logic                pend_valid;
  logic                out_free;

  // combinational helpers
  logic [SAMPLE_W-1:0]        left;
  logic [SAMPLE_W-1:0]        right;
  logic [SAMPLE_W:0]          mix_sum;
  logic [SAMPLE_W:0]          mix_adj;
  logic [SAMPLE_W-1:0]        x_in;
  logic [RATE_W:0]            ceil_num;
  logic [RATE_W:0]            total;
  logic [2*RATE_W-1:0]        ns_full;
  logic signed [NUM_W-1:0]    at_full;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [NUM_W-1:0]    prod_full;
  logic                       neg;
  logic [NUM_W-1:0]           mag;
  logic [SAMPLE_W-1:0]        q_low;

  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [RATE_W-1:0] div_divisor;
  logic              div_done;
  logic [DVD_W-1:0]  div_quot;
  logic [RATE_W-1:0] div_rem;

  assign s_eff = (src_rate == '0) ? RATE_W'(1) : src_rate;
  assign t_eff = (tgt_rate == '0) ? RATE_W'(1) : tgt_rate;

  // stereo downmix, halved toward zero
  assign left    = s_tdata[15:0];
  assign right   = s_tdata[31:16];
  assign mix_sum = {left[SAMPLE_W-1], left} + {right[SAMPLE_W-1], right};
  assign mix_adj = mix_sum + {{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]};
  assign x_in    = stereo ? mix_adj[SAMPLE_W:1] : left;

  assign ceil_num  = {1'b0, t_eff} - {1'b0, rem} + {1'b0, s_eff} - (RATE_W+1)'(1);
  assign total     = {1'b0, rem} + ns;
  assign ns_full   = n * s_eff;
  assign at_full   = a * $signed({1'b0, t_eff});
  assign diff      = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
  assign prod_full = diff * $signed({1'b0, r[RATE_W-1:0]});
  assign neg       = num[NUM_W-1];
  assign mag       = neg ? -num : num;
  assign q_low     = div_quot[SAMPLE_W-1:0];

  assign div_start = (cmd.op == OP_FOLD_START) || (cmd.op == OP_CEIL_START) ||
                     (cmd.op == OP_TOT_START) || (cmd.op == OP_QUOT_START);

  always_comb begin
    div_dividend = '0;
    div_divisor  = t_eff;
    case (cmd.op)
      OP_FOLD_START: div_dividend = DVD_W'(npr);
      OP_CEIL_START: begin
        div_dividend = DVD_W'(ceil_num);
        div_divisor  = s_eff;
      end
      OP_TOT_START:  div_dividend = DVD_W'(total);
      OP_QUOT_START: div_dividend = mag[DVD_W-1:0];
      default:       div_dividend = '0;
    endcase
  end

  mlr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign out_free = !out_valid || m_tready;

  assign stat.in_valid  = s_tvalid;
  assign stat.have_prev = have_prev;
  assign stat.last      = last;
  assign stat.fold_need = npr >= t_eff;
  assign stat.hit       = npi == k;
  assign stat.more      = (r < {1'b0, t_eff}) && (count < CNT_W'(CAP));
  assign stat.div_done  = div_done;
  assign stat.put_ok    = (last && !pend_valid) || out_free;
  assign stat.flush_ok  = !pend_valid || out_free;

  // control and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      stereo     <= 1'b0;
      src_rate   <= RATE_RESET;
      tgt_rate   <= RATE_RESET;
      prev       <= '0;
      have_prev  <= 1'b0;
      in_idx     <= '0;
      npi        <= '0;
      npr        <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_STEREO: stereo   <= cfg_data[0];
          REG_SOURCE: src_rate <= cfg_data;
          REG_TARGET: tgt_rate <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (cmd.op)
        OP_FOLD_DONE,
        OP_TOT_DONE: begin
          npi <= npi + div_quot[IDX_W-1:0];
          npr <= div_rem;
        end
        OP_PUT: begin
          if (!last || pend_valid) out_valid <= 1'b1;
          if (last) pend_valid <= 1'b1;
        end
        OP_ADVANCE: begin
          prev      <= x;
          have_prev <= 1'b1;
          in_idx    <= in_idx + IDX_W'(1);
        end
        OP_FLUSH: begin
          if (pend_valid) out_valid <= 1'b1;
          pend_valid <= 1'b0;
          prev       <= '0;
          have_prev  <= 1'b0;
          in_idx     <= '0;
          npi        <= '0;
          npr        <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        x     <= x_in;
        last  <= s_tlast;
        count <= '0;
      end
      OP_SETUP_PAIR: begin
        k <= in_idx - IDX_W'(1);
        a <= prev;
        b <= x;
      end
      OP_SETUP_TAIL: begin
        k <= in_idx;
        a <= x;
        b <= x;
      end
      OP_FOLD_DONE:  rem <= div_rem;
      OP_NO_FOLD:    rem <= npr;
      OP_CEIL_START: begin
        at <= at_full;
        r  <= {1'b0, rem};
      end
      OP_CEIL_DONE:  n <= div_quot[RATE_W-1:0];
      OP_STEP_MUL:   ns <= ns_full[RATE_W:0];
      OP_INTERP_MUL: prod <= prod_full;
      OP_SUM:        num <= at + prod;
      OP_QUOT_DONE: begin
        val <= neg ? -q_low : q_low;
        r   <= r + {1'b0, s_eff};
      end
      OP_PUT: begin
        count <= count + CNT_W'(1);
        if (last) begin
          // hold the newest word back until it is known not to be the final one
          pend <= val;
          if (pend_valid) begin
            out_sample <= pend;
            out_final  <= 1'b0;
          end
        end else begin
          out_sample <= val;
          out_final  <= 1'b0;
        end
      end
      OP_FLUSH: begin
        if (pend_valid) begin
          out_sample <= pend;
          out_final  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_tready  = cmd.in_ready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_sample;
  assign m_tlast   = out_final;
  assign cfg_ready = 1'b1;

endmodule

// File: src/mlr_ctrl.sv
// Resampler controller: sequences each frame through the datapath.
module mlr_ctrl import mlr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_START     = 17'h00002,
    S_FOLD      = 17'h00004,
    S_FOLD_WAIT = 17'h00008,
    S_CHECK     = 17'h00010,
    S_CEIL_WAIT = 17'h00020,
    S_STEP      = 17'h00040,
    S_TOT       = 17'h00080,
    S_TOT_WAIT  = 17'h00100,
    S_LOOP      = 17'h00200,
    S_SUM       = 17'h00400,
    S_QUOT      = 17'h00800,
    S_QUOT_WAIT = 17'h01000,
    S_PUT       = 17'h02000,
    S_EMIT_END  = 17'h04000,
    S_FINISH    = 17'h08000,
    S_FLUSH     = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   tail;
  logic   tail_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= 1'b0;
    end else begin
      state <= state_next;
      tail  <= tail_next;
    end
  end

  always_comb begin
    state_next   = state;
    tail_next    = tail;
    cmd.op       = OP_NONE;
    cmd.in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.have_prev) begin
          cmd.op     = OP_SETUP_PAIR;
          tail_next  = 1'b0;
          state_next = S_FOLD;
        end else if (stat.last) begin
          cmd.op     = OP_SETUP_TAIL;
          tail_next  = 1'b1;
          state_next = S_FOLD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FOLD: begin
        if (stat.fold_need) begin
          cmd.op     = OP_FOLD_START;
          state_next = S_FOLD_WAIT;
        end else begin
          cmd.op     = OP_NO_FOLD;
          state_next = S_CHECK;
        end
      end
      S_FOLD_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_FOLD_DONE;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.hit) begin
          cmd.op     = OP_CEIL_START;
          state_next = S_CEIL_WAIT;
        end else begin
          state_next = S_EMIT_END;
        end
      end
      S_CEIL_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_CEIL_DONE;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.op     = OP_STEP_MUL;
        state_next = S_TOT;
      end
      S_TOT: begin
        cmd.op     = OP_TOT_START;
        state_next = S_TOT_WAIT;
      end
      S_TOT_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_TOT_DONE;
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.more) begin
          cmd.op     = OP_INTERP_MUL;
          state_next = S_SUM;
        end else begin
          state_next = S_EMIT_END;
        end
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_QUOT;
      end
      S_QUOT: begin
        cmd.op     = OP_QUOT_START;
        state_next = S_QUOT_WAIT;
      end
      S_QUOT_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_QUOT_DONE;
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (stat.put_ok) begin
          cmd.op     = OP_PUT;
          state_next = S_LOOP;
        end
      end
      S_EMIT_END: begin
        if (!tail && stat.last) begin
          // the final frame also covers the outputs past the last sample
          cmd.op     = OP_SETUP_TAIL;
          tail_next  = 1'b1;
          state_next = S_FOLD;
        end else if (stat.last) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.op     = OP_ADVANCE;
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (stat.flush_ok) begin
          cmd.op     = OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/mlr_checker.sv
// Port-level assertions for the resampler, bound to the top level.
module mlr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // one frame at a time: a taken word drops ready
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready stayed high after a word was taken");

  // output words are only produced while a frame is in work
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("output word appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind mono_linear_resampler mlr_checker u_mlr_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);

// File: tb/sv/mono_linear_resampler_test.sv
// Self-checking testbench for mono_linear_resampler: predicts every output word and compares.
`timescale 1ns / 1ps

module mono_linear_resampler_test;
  import mlr_pkg::*;

  localparam int MAX_RATIO = DEFAULT_MAX_RATE_RATIO;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_FRAMES = 76;
  localparam int QUIET_FROM = 60;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] sample;
    logic        fin;
  } out_word_t;

  // Holds the expected output words and a bit-exact copy of the resampler state.
  class resample_checker;
    out_word_t        due_words[$];
    out_word_t        step_words[$];
    int               errors;
    int               cap;
    bit               stereo;
    logic [RATE_W-1:0] src_rate;
    logic [RATE_W-1:0] dst_rate;
    longint           prev_x;
    bit               have_prev;
    logic [31:0]      in_idx;
    logic [31:0]      pos_idx;
    logic [RATE_W-1:0] pos_rem;

    function new(int max_ratio);
      cap = (2 * max_ratio < RESULT_LIMIT) ? 2 * max_ratio : RESULT_LIMIT;
      errors = 0;
      stereo = 1'b0;
      src_rate = RATE_RESET;
      dst_rate = RATE_RESET;
      prev_x = 0;
      have_prev = 1'b0;
      in_idx = '0;
      pos_idx = '0;
      pos_rem = '0;
    endfunction

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [RATE_W-1:0] d);
      case (idx)
        REG_STEREO: stereo = d[0];
        REG_SOURCE: src_rate = d;
        REG_TARGET: dst_rate = d;
        default: ;
      endcase
    endfunction

    // Interpolate every output whose integer position is k, between a and b.
    function void emit_at_index(logic [31:0] k, longint a, longint b);
      longint unsigned s, t, rem, n, total;
      longint r, num, tl;
      out_word_t w;
      s = (src_rate == '0) ? 64'd1 : 64'(src_rate);
      t = (dst_rate == '0) ? 64'd1 : 64'(dst_rate);
      tl = longint'(t);
      rem = 64'(pos_rem);
      // fold a remainder left past one period by a rate change
      if (rem >= t) begin
        pos_idx = pos_idx + 32'(rem / t);
        rem = rem % t;
        pos_rem = RATE_W'(rem);
      end
      if (pos_idx != k) return;
      n = (t - rem + s - 1) / s;
      for (longint unsigned j = 0; j < n && step_words.size() < cap; j++) begin
        r = longint'(rem + j * s);
        num = a * (tl - r) + b * r;
        w.sample = 16'(num / tl);
        w.fin = 1'b0;
        step_words.push_back(w);
      end
      total = rem + n * s;
      pos_idx = pos_idx + 32'(total / t);
      pos_rem = RATE_W'(total % t);
    endfunction

    function void take_frame(logic [15:0] left, logic [15:0] right, logic eos);
      longint lv, rv, x;
      out_word_t w;
      lv = $signed(left);
      rv = $signed(right);
      x = stereo ? (lv + rv) / 2 : lv;
      step_words.delete();
      if (have_prev) emit_at_index(in_idx - 32'd1, prev_x, x);
      if (eos) begin
        emit_at_index(in_idx, x, x);
        if (step_words.size() > 0) begin
          w = step_words.pop_back();
          w.fin = 1'b1;
          step_words.push_back(w);
        end
        prev_x = 0;
        have_prev = 1'b0;
        in_idx = '0;
        pos_idx = '0;
        pos_rem = '0;
      end else begin
        prev_x = x;
        have_prev = 1'b1;
        in_idx = in_idx + 32'd1;
      end
      foreach (step_words[i]) due_words.push_back(step_words[i]);
    endfunction

    function void match_word(logic [15:0] sample, logic fin);
      out_word_t w;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual sample %h last %b",
                 $time, sample, fin);
        errors++;
        return;
      end
      w = due_words.pop_front();
      if (w.sample !== sample) begin
        $display("%0t: out_sample expected %h actual %h", $time, w.sample, sample);
        errors++;
      end
      if (w.fin !== fin) begin
        $display("%0t: final_flag expected %b actual %b", $time, w.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // left_sample [15:0], right_sample [31:16]
  logic                 s_tlast = 1'b0; // end_of_stream
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;        // out_sample [15:0]
  logic                 m_tlast;        // final_flag
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_data = '0;

  resample_checker chk = new(MAX_RATIO);
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  mono_linear_resampler #(.MAX_RATE_RATIO(MAX_RATIO)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Output side: check accepted words, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) chk.match_word(m_tdata, m_tlast);
      if (quiet) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("mono_linear_resampler verification failed");
        $finish;
      end
    end
  end

  // Drive one frame; valid stays high so a following frame can go back to back.
  task automatic send_frame(logic [15:0] left, logic [15:0] right, logic eos);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {right, left};
    s_tlast <= eos;
    do @(posedge clk); while (!s_tready);
    chk.take_frame(left, right, eos);
  endtask

  // Drop valid, wait for every expected word, then let the block finish its frame.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (chk.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(logic [REG_IDX_W-1:0] idx, logic [RATE_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    chk.set_register(idx, d);
  endtask

  task automatic configure(bit st, logic [RATE_W-1:0] src, logic [RATE_W-1:0] dst, bit poke);
    settle();
    cfg_word(REG_STEREO, {17'($urandom_range(0, 131071)), st});
    cfg_word(REG_SOURCE, src);
    cfg_word(REG_TARGET, dst);
    if (poke) cfg_word(REG_UNUSED, RATE_W'($urandom_range(0, 262143)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    int k;
    k = $urandom_range(0, 19);
    case (k)
      0: return 18'd8000;
      1: return 18'd11025;
      2: return 18'd16000;
      3: return 18'd22050;
      4: return 18'd32000;
      5: return 18'd44100;
      6: return 18'd48000;
      7: return 18'd96000;
      8: return 18'd192000;
      15, 16, 17: return $urandom_range(0, 1) ? 18'd1000 : 18'd192000;
      18: return $urandom_range(0, 1) ? 18'd0 : 18'h3FFFF;
      19: return RATE_W'($urandom_range(0, 262143));
      default: return RATE_W'($urandom_range(1000, 192000));
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    logic eos;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unity ratio, mono, sample extremes
    configure(1'b0, 18'd44100, 18'd44100, 1'b0);
    send_frame(16'h7FFF, 16'h0000, 1'b0);
    send_frame(16'h8000, 16'hFFFF, 1'b0);
    send_frame(16'h0000, 16'h7FFF, 1'b0);
    send_frame(16'hFFFF, 16'h8000, 1'b0);
    send_frame(16'h0001, 16'h1234, 1'b1);

    // stereo downmix at the largest allowed upsampling; odd sums truncate toward zero
    configure(1'b1, 18'd1000, 18'd8000, 1'b1);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'hFFFF, 1'b0);
    send_frame(16'hFFFD, 16'h0000, 1'b1);

    // strong downsampling: the end frame brings no word, so none carries the flag
    configure(1'b0, 18'd192000, 18'd1000, 1'b0);
    send_frame(16'h1234, 16'h0000, 1'b0);
    send_frame(16'hEDCB, 16'h0000, 1'b0);
    send_frame(16'h4321, 16'h0000, 1'b0);
    send_frame(16'h0F0F, 16'h0000, 1'b1);
    // a stream of one frame
    send_frame(16'h4000, 16'h0000, 1'b1);

    // zero rates act as one; the ratio far past the limit drops words
    configure(1'b0, 18'd0, 18'd192000, 1'b0);
    send_frame(16'h7FFF, 16'h0000, 1'b0);
    send_frame(16'h8000, 16'h0000, 1'b1);
    configure(1'b1, 18'h3FFFF, 18'd0, 1'b1);
    send_frame(16'h5555, 16'hAAAA, 1'b0);
    send_frame(16'hAAAA, 16'h5555, 1'b1);

    // rate change in the middle of a stream leaves the remainder past one period
    configure(1'b0, 18'd44100, 18'd48000, 1'b0);
    send_frame(16'h1000, 16'h0000, 1'b0);
    send_frame(16'h2000, 16'h0000, 1'b0);
    send_frame(16'hE000, 16'h0000, 1'b0);
    configure(1'b0, 18'd44100, 18'd1000, 1'b0);
    send_frame(16'h3000, 16'h0000, 1'b0);
    send_frame(16'hC000, 16'h0000, 1'b1);

    while (sent < RANDOM_FRAMES) begin
      configure(1'($urandom_range(0, 1)), pick_rate(), pick_rate(), $urandom_range(0, 7) == 0);
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        eos = (i == len - 1) && ($urandom_range(0, 9) != 0);
        send_frame(pick_sample(), pick_sample(), eos);
        sent++;
        if (sent >= QUIET_FROM) quiet = 1'b1;
      end
    end

    settle();
    if (chk.errors == 0 && chk.due_words.size() == 0) begin
      $display("mono_linear_resampler verification clean");
    end else begin
      if (chk.due_words.size() != 0)
        $display("%0t: %0d expected words never arrived", $time, chk.due_words.size());
      $display("mono_linear_resampler verification failed");
    end
    $finish;
  end

endmodule
